// ===== rtl/core/rosg_pkg.sv =====
package rosg_pkg;

  // Field widths fixed by the item format
  localparam int POS_W   = 11;
  localparam int VALUE_W = 32;
  localparam int ACT_W   = 2;

  // Defaults for the top-level parameters
  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int MASK_WIDTH_DEF    = 32;

  // Positions in use after reset
  localparam int RESET_POSITIONS = 1024;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // Status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   range_first;
    logic [POS_W-1:0]   range_last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] or_result;
    logic               status;
  } out_item_t;

endpackage

// ===== rtl/core/rosg_ram.sv =====
module rosg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/range_or_segment_tree_unit.sv =====
// Range-OR segment tree. Node masks live in one memory of 4*MAX_POSITIONS
// entries (one write and one registered read port); node 1 spans positions
// 1 to positions_in_use. An item is taken when start is high and busy is
// low; unless a cfg write cuts it short, each item yields exactly one
// result, shown on out_item for a single cycle with out_valid; the
// receiver cannot stall it, so it must take it in that cycle. A rejected
// item or an unknown action answers in the next cycle; an update walks
// root to leaf with one read-OR-write per node, overlapped with the next
// node's read; a query walks both range edges, reading each fully covered
// node; a clear sweeps the whole memory of 4*MAX_POSITIONS entries (4096
// by default). The same sweep runs after reset and after every write of
// positions_in_use, with busy high throughout; cfg_ready is always high
// and cfg writes are taken at any time.
module range_or_segment_tree_unit #(
  parameter int MAX_POSITIONS = rosg_pkg::MAX_POSITIONS_DEF,
  parameter int MASK_WIDTH    = rosg_pkg::MASK_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rosg_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output rosg_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rosg_pkg::POS_W-1:0]    cfg_data
);

  localparam int PW         = rosg_pkg::POS_W;
  localparam int VW         = rosg_pkg::VALUE_W;
  localparam int NODE_COUNT = 4 * MAX_POSITIONS;
  localparam int NW         = $clog2(NODE_COUNT);
  localparam logic [NW-1:0] CLR_LAST = NW'(NODE_COUNT - 1);
  localparam logic [NW-1:0] ROOT     = NW'(1);
  localparam logic [PW-1:0] RST_SPAN =
      (rosg_pkg::RESET_POSITIONS > MAX_POSITIONS) ? PW'(MAX_POSITIONS)
                                                  : PW'(rosg_pkg::RESET_POSITIONS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_UPD,
    ST_QRY,
    ST_QFIN
  } state_t;

  // control
  state_t              state_r, state_nxt;
  logic [NW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                clr_reply_r, clr_reply_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PW-1:0]       span_r, span_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic                rd_q_r, rd_q_nxt;

  // walker payload
  logic [NW-1:0]         node_r, node_nxt;
  logic [PW-1:0]         lo_r, lo_nxt;
  logic [PW-1:0]         hi_r, hi_nxt;
  logic [PW-1:0]         qa_r, qa_nxt;
  logic [PW-1:0]         qb_r, qb_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [MASK_WIDTH-1:0] val_r, val_nxt;
  logic [MASK_WIDTH-1:0] acc_r, acc_nxt;
  logic [NW-1:0]         pend_node_r, pend_node_nxt;
  logic [PW-1:0]         pend_lo_r, pend_lo_nxt;
  logic [PW-1:0]         pend_hi_r, pend_hi_nxt;
  logic [PW-1:0]         pend_qb_r, pend_qb_nxt;
  rosg_pkg::out_item_t   out_item_r, out_item_nxt;

  // memory port
  logic                  wr_en;
  logic [NW-1:0]         wr_addr;
  logic [MASK_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [NW-1:0]         rd_addr;
  logic [MASK_WIDTH-1:0] rd_data;

  // helpers
  logic                  accept;
  logic [PW:0]           mid_sum;
  logic [PW-1:0]         mid;
  logic [PW-1:0]         mid_p1;
  logic [NW-1:0]         child_l;
  logic [NW-1:0]         child_r;
  logic [MASK_WIDTH-1:0] acc_in;
  logic [MASK_WIDTH+VW-1:0] val_ext;
  logic [MASK_WIDTH+VW-1:0] res_ext;
  logic [PW-1:0]         cfg_span;

  rosg_ram #(
    .WIDTH (MASK_WIDTH),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // node split point and children
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[PW:1];
  assign mid_p1  = mid + PW'(1);
  assign child_l = {node_r[NW-2:0], 1'b0};
  assign child_r = {node_r[NW-2:0], 1'b1};

  // fold in the node read issued last cycle
  assign acc_in  = rd_q_r ? (acc_r | rd_data) : acc_r;

  // value truncated or zero-extended to the mask width
  assign val_ext = {{MASK_WIDTH{1'b0}}, in_item.value};
  assign res_ext = {{VW{1'b0}}, acc_in};

  // clamp written register into 1..MAX_POSITIONS
  always_comb begin
    if (cfg_data == '0) begin
      cfg_span = PW'(1);
    end else if (int'(cfg_data) > MAX_POSITIONS) begin
      cfg_span = PW'(MAX_POSITIONS);
    end else begin
      cfg_span = cfg_data;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_reply_nxt  = clr_reply_r;
    out_valid_nxt  = 1'b0;
    span_nxt       = span_r;
    pend_valid_nxt = pend_valid_r;
    rd_q_nxt       = 1'b0;
    node_nxt       = node_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    qa_nxt         = qa_r;
    qb_nxt         = qb_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    acc_nxt        = acc_r;
    pend_node_nxt  = pend_node_r;
    pend_lo_nxt    = pend_lo_r;
    pend_hi_nxt    = pend_hi_r;
    pend_qb_nxt    = pend_qb_r;
    out_item_nxt   = out_item_r;
    wr_en          = 1'b0;
    wr_addr        = node_r;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = node_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_item_nxt.or_result = '0;
          out_item_nxt.status    = rosg_pkg::STAT_BAD;
          case (in_item.action)
            rosg_pkg::ACT_CLEAR: begin
              state_nxt     = ST_CLR;
              clr_cnt_nxt   = '0;
              clr_reply_nxt = 1'b1;
            end
            rosg_pkg::ACT_UPDATE: begin
              if (in_item.position == '0 || in_item.position > span_r) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_UPD;
                node_nxt  = ROOT;
                lo_nxt    = PW'(1);
                hi_nxt    = span_r;
                pos_nxt   = in_item.position;
                val_nxt   = val_ext[MASK_WIDTH-1:0];
                rd_en     = 1'b1;
                rd_addr   = ROOT;
              end
            end
            rosg_pkg::ACT_QUERY: begin
              if (in_item.range_first == '0 || in_item.range_last > span_r ||
                  in_item.range_first > in_item.range_last) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt      = ST_QRY;
                node_nxt       = ROOT;
                lo_nxt         = PW'(1);
                hi_nxt         = span_r;
                qa_nxt         = in_item.range_first;
                qb_nxt         = in_item.range_last;
                acc_nxt        = '0;
                pend_valid_nxt = 1'b0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // zero one entry per cycle
      ST_CLR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + NW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt     = ST_IDLE;
          clr_reply_nxt = 1'b0;
          if (clr_reply_r) begin
            out_valid_nxt          = 1'b1;
            out_item_nxt.or_result = '0;
            out_item_nxt.status    = rosg_pkg::STAT_OK;
          end
        end
      end

      // each node on the path gains the value; read of the child overlaps
      ST_UPD: begin
        wr_en   = 1'b1;
        wr_addr = node_r;
        wr_data = rd_data | val_r;
        if (lo_r == hi_r) begin
          state_nxt              = ST_IDLE;
          out_valid_nxt          = 1'b1;
          out_item_nxt.or_result = '0;
          out_item_nxt.status    = rosg_pkg::STAT_OK;
        end else if (pos_r <= mid) begin
          node_nxt = child_l;
          hi_nxt   = mid;
          rd_en    = 1'b1;
          rd_addr  = child_l;
        end else begin
          node_nxt = child_r;
          lo_nxt   = mid_p1;
          rd_en    = 1'b1;
          rd_addr  = child_r;
        end
      end

      // walk the range edges, reading fully covered nodes
      ST_QRY: begin
        acc_nxt = acc_in;
        if (lo_r == qa_r && hi_r == qb_r) begin
          rd_en    = 1'b1;
          rd_addr  = node_r;
          rd_q_nxt = 1'b1;
          if (pend_valid_r) begin
            pend_valid_nxt = 1'b0;
            node_nxt       = pend_node_r;
            lo_nxt         = pend_lo_r;
            hi_nxt         = pend_hi_r;
            qa_nxt         = pend_lo_r;
            qb_nxt         = pend_qb_r;
          end else begin
            state_nxt = ST_QFIN;
          end
        end else if (qb_r <= mid) begin
          node_nxt = child_l;
          hi_nxt   = mid;
        end else if (qa_r > mid) begin
          node_nxt = child_r;
          lo_nxt   = mid_p1;
        end else if (qa_r == lo_r) begin
          // left half fully covered
          rd_en    = 1'b1;
          rd_addr  = child_l;
          rd_q_nxt = 1'b1;
          node_nxt = child_r;
          lo_nxt   = mid_p1;
          qa_nxt   = mid_p1;
        end else if (qb_r == hi_r) begin
          // right half fully covered
          rd_en    = 1'b1;
          rd_addr  = child_r;
          rd_q_nxt = 1'b1;
          node_nxt = child_l;
          hi_nxt   = mid;
          qb_nxt   = mid;
        end else begin
          // first real split: park the right part
          pend_valid_nxt = 1'b1;
          pend_node_nxt  = child_r;
          pend_lo_nxt    = mid_p1;
          pend_hi_nxt    = hi_r;
          pend_qb_nxt    = qb_r;
          node_nxt       = child_l;
          hi_nxt         = mid;
          qb_nxt         = mid;
        end
      end

      // last read lands, report
      ST_QFIN: begin
        state_nxt              = ST_IDLE;
        out_valid_nxt          = 1'b1;
        out_item_nxt.or_result = res_ext[VW-1:0];
        out_item_nxt.status    = rosg_pkg::STAT_OK;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write resizes the tree and wipes the store
    if (cfg_valid) begin
      span_nxt      = cfg_span;
      state_nxt     = ST_CLR;
      clr_cnt_nxt   = '0;
      clr_reply_nxt = (state_r == ST_CLR) ? clr_reply_r : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_cnt_r    <= '0;
      clr_reply_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      span_r       <= RST_SPAN;
      pend_valid_r <= 1'b0;
      rd_q_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_reply_r  <= clr_reply_nxt;
      out_valid_r  <= out_valid_nxt;
      span_r       <= span_nxt;
      pend_valid_r <= pend_valid_nxt;
      rd_q_r       <= rd_q_nxt;
    end
    node_r      <= node_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    qa_r        <= qa_nxt;
    qb_r        <= qb_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    acc_r       <= acc_nxt;
    pend_node_r <= pend_node_nxt;
    pend_lo_r   <= pend_lo_nxt;
    pend_hi_r   <= pend_hi_nxt;
    pend_qb_r   <= pend_qb_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

// ===== tb/sv/or_tree_checker.sv =====
module or_tree_checker
  import rosg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  in_item_t            in_item,
  input  logic                out_valid,
  input  out_item_t           out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [POS_W-1:0]    cfg_data,
  output int                  fail_count,
  output int                  results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Flat leaf view of the tree: a range OR over leaves equals the tree walk
  logic [VALUE_W-1:0] leaf_mask [1:MAX_POSITIONS_DEF];
  logic [POS_W-1:0]   span_cfg;
  out_item_t          owed_q [$];

  function automatic void clear_leaves();
    foreach (leaf_mask[p]) leaf_mask[p] = '0;
  endfunction

  // Applies one item to the local store and returns the result it should give
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t          res;
    int                 lim;
    logic [VALUE_W-1:0] acc;
    res.or_result = '0;
    res.status    = STAT_OK;
    // zero acts as one position, anything past the store acts as full size
    if (span_cfg == 0) lim = 1;
    else if (span_cfg > MAX_POSITIONS_DEF) lim = MAX_POSITIONS_DEF;
    else lim = int'(span_cfg);
    case (it.action)
      ACT_CLEAR: clear_leaves();
      ACT_UPDATE: begin
        if (it.position == 0 || int'(it.position) > lim) res.status = STAT_BAD;
        else leaf_mask[it.position] |= it.value;
      end
      ACT_QUERY: begin
        if (it.range_first == 0 || int'(it.range_last) > lim ||
            it.range_first > it.range_last) begin
          res.status = STAT_BAD;
        end else begin
          acc = '0;
          for (int p = int'(it.range_first); p <= int'(it.range_last); p++)
            acc |= leaf_mask[p];
          res.or_result = acc;
        end
      end
      default: res.status = STAT_BAD;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Monitor: results first, then register writes, then accepted items
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_leaves();
      span_cfg = POS_W'(RESET_POSITIONS);
      owed_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("result %h/%0b with nothing pending",
                                    out_item.or_result, out_item.status));
        end else begin
          want = owed_q.pop_front();
          if (out_item.or_result !== want.or_result)
            report_mismatch($sformatf("or_result %h, want %h",
                                      out_item.or_result, want.or_result));
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status %b, want %b",
                                      out_item.status, want.status));
        end
      end
      // a size change reshapes the tree, so the store starts empty
      if (cfg_valid && cfg_ready) begin
        span_cfg = cfg_data;
        clear_leaves();
      end
      if (start && !busy) owed_q.push_back(apply_item(in_item));
    end
    results_owed <= owed_q.size();
  end

endmodule

// ===== tb/sv/tb_range_or_segment_tree_unit.sv =====
module tb_range_or_segment_tree_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rosg_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;
  localparam int MAX_GAP = 40;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_valid;
  out_item_t          out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [POS_W-1:0]   cfg_data;
  int                 fail_count;
  int                 results_owed;

  int                 tree_span;
  int                 idle_pct;
  logic [POS_W-1:0]   span_plan [8];
  int                 idle_plan [4] = '{0, 52, 0, 37};

  range_or_segment_tree_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  or_tree_checker u_or_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: covers every item being a full clear sweep plus the longest gap
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_item_t item_of(logic [ACT_W-1:0] act, int pos, logic [31:0] val,
                                       int lo, int hi);
    in_item_t it;
    it.action      = act;
    it.position    = POS_W'(pos);
    it.value       = val;
    it.range_first = POS_W'(lo);
    it.range_last  = POS_W'(hi);
    return it;
  endfunction

  // Mostly well-formed updates and queries inside the live span, some noise
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       lo;
    int       hi;
    it.action      = ACT_W'($urandom);
    it.position    = POS_W'($urandom);
    it.value       = $urandom;
    it.range_first = POS_W'($urandom);
    it.range_last  = POS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      it.action = ACT_CLEAR;
    end else if (pick < 45) begin
      it.action   = ACT_UPDATE;
      it.position = POS_W'($urandom_range(1, tree_span));
      if ($urandom_range(0, 1) == 0) it.value = 32'h1 << $urandom_range(0, 31);
    end else if (pick < 88) begin
      it.action = ACT_QUERY;
      lo = $urandom_range(1, tree_span);
      case ($urandom_range(0, 3))
        0: hi = lo;
        1: begin
          hi = lo + $urandom_range(0, 15);
          if (hi > tree_span) hi = tree_span;
        end
        2: begin
          lo = 1;
          hi = tree_span;
        end
        default: hi = $urandom_range(lo, tree_span);
      endcase
      it.range_first = POS_W'(lo);
      it.range_last  = POS_W'(hi);
    end else if (pick < 92) begin
      it.action = ACT_UNDEF;
    end else if (pick < 96) begin
      // update outside the span
      it.action   = ACT_UPDATE;
      it.position = ($urandom_range(0, 1) == 0) ? '0 :
                    POS_W'($urandom_range(tree_span + 1, 2047));
    end else begin
      // broken query range
      it.action = ACT_QUERY;
      case ($urandom_range(0, 2))
        0: begin
          lo = 0;
          hi = $urandom_range(0, tree_span);
        end
        1: begin
          lo = $urandom_range(1, tree_span);
          hi = $urandom_range(tree_span + 1, 2047);
        end
        default: begin
          if (tree_span >= 2) begin
            hi = $urandom_range(1, tree_span - 1);
            lo = $urandom_range(hi + 1, tree_span);
          end else begin
            lo = 0;
            hi = 1;
          end
        end
      endcase
      it.range_first = POS_W'(lo);
      it.range_last  = POS_W'(hi);
    end
    return it;
  endfunction

  // Presents one item and returns at the edge that takes it
  task automatic send_item(input in_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // Holds off until every pending result is back and the block is idle
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0 || busy);
  endtask

  task automatic write_span(input logic [POS_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (v == 0) tree_span = 1;
    else if (v > MAX_POSITIONS_DEF) tree_span = MAX_POSITIONS_DEF;
    else tree_span = int'(v);
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    tree_span = RESET_POSITIONS;
    idle_pct  = 0;
    span_plan = '{11'd0, 11'd2047, 11'd1, 11'd2, POS_W'($urandom_range(3, 63)),
                  11'd1024, 11'd1025, POS_W'($urandom_range(64, 1023))};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: span edges, bad positions and ranges, unknown action, clear
    send_item(item_of(ACT_QUERY, 0, 32'h0, 1, 1024));
    send_item(item_of(ACT_UPDATE, 1, 32'h0000_0001, 0, 0));
    send_item(item_of(ACT_UPDATE, 1024, 32'h8000_0000, 2047, 2047));
    send_item(item_of(ACT_UPDATE, 512, 32'h00F0_0000, 0, 0));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 1, 1));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 1024, 1024));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 1, 1024));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 2, 1023));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 513, 1024));
    send_item(item_of(ACT_UPDATE, 0, 32'hFFFF_FFFF, 0, 0));
    send_item(item_of(ACT_UPDATE, 1025, 32'hFFFF_FFFF, 0, 0));
    send_item(item_of(ACT_UPDATE, 2047, 32'hFFFF_FFFF, 0, 0));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 0, 5));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 1, 1025));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 600, 599));
    send_item(item_of(ACT_UNDEF, 2047, 32'hFFFF_FFFF, 2047, 2047));
    send_item(item_of(ACT_UPDATE, 700, 32'hFFFF_FFFF, 0, 0));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 513, 1024));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 1, 511));
    send_item(item_of(ACT_CLEAR, 2047, 32'hFFFF_FFFF, 2047, 2047));
    send_item(item_of(ACT_QUERY, 0, 32'h0, 1, 1024));
    send_item(item_of(ACT_CLEAR, 0, 32'h0, 0, 0));

    // Random phases, one span setting each, sender idling varied
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = idle_plan[ph % 4];
      write_span(span_plan[ph]);
      for (int k = 0; k < 135; k++) begin
        if (k == 60) drain_results();
        send_item(random_item());
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
